@@ src/fixed_block_pool_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Fixed block pool allocator assertion macros
// Concurrent checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FBPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Field widths, command, status and register codes of the block pool.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int CMD_W      = 2;
    localparam int BIDX_W     = 12;
    localparam int STAT_W     = 2;
    localparam int GIDX_W     = 10;
    localparam int OFF_W      = 26;
    localparam int BCNT_W     = 11;
    localparam int BSIZE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int BCNT_RESET  = 1024;
    localparam int BSIZE_RESET = 64;

    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_STACK_FULL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;

endpackage

@@ src/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool; free stack and used flags share one packed table.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+-----------
//   command | s_valid s_ready s_command s_block_index  | in
//   result  | m_valid m_ready m_status m_granted_index | out
//           | m_block_offset m_is_free                 |
//   config  | cfg_valid cfg_ready cfg_index cfg_data   | in
//
// Table reads are registered, so each lookup waits on the RAM read register.
// Alloc pops entries until one is in range and not used; free clears a used
// block's flag and pushes it unless the stack is full; query reads the flag.
// A command is taken only in ST_IDLE, when no other command is in flight.
// Reset and init run a clearing pass that loads the identity table.
// A stalled result holds in the output register while the next command runs.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [BIDX_W-1:0]     s_block_index,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STAT_W-1:0]     m_status,
    output logic [GIDX_W-1:0]     m_granted_index,
    output logic [OFF_W-1:0]      m_block_offset,
    output logic                  m_is_free,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "fixed_block_pool_allocator_assert.svh"

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = (CW > BCNT_W) ? CW : BCNT_W;
    localparam int BW = (CW > BIDX_W) ? CW : BIDX_W;
    localparam int PW = BSIZE_W + IW;
    localparam int RESET_FREE = (BCNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : BCNT_RESET;

    typedef enum logic [3:0] {
        ST_WALK,
        ST_IDLE,
        ST_POP,
        ST_CAND,
        ST_CHK,
        ST_FREE_CHK,
        ST_FREE_RDS,
        ST_FREE_SLOT,
        ST_QRY_CHK,
        ST_MUL,
        ST_OUT
    } state_t;

    // configuration
    logic [BCNT_W-1:0]  block_count_reg;
    logic [BSIZE_W-1:0] block_size_reg;
    logic [CW-1:0]      live_cnt;

    // sequencer
    state_t             state_reg, state_next;
    logic [IW-1:0]      walk_reg, walk_next;
    logic               walk_cmd_reg, walk_cmd_next;
    logic [CW-1:0]      fc_reg, fc_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      bi_reg, bi_next;
    logic [IW-1:0]      cand_reg, cand_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [IW-1:0]      res_idx_reg, res_idx_next;
    logic               res_free_reg, res_free_next;
    logic [PW-1:0]      prod_reg, prod_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [GIDX_W-1:0]  m_gidx_reg, m_gidx_next;
    logic [OFF_W-1:0]   m_off_reg, m_off_next;
    logic               m_free_reg, m_free_next;
    logic               load_out;

    // table RAM
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [IW:0]        ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [IW:0]        ram_rdata;

    fbpa_ram #(
        .WIDTH (IW + 1),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= BCNT_W'(BCNT_RESET);
            block_size_reg  <= BSIZE_W'(BSIZE_RESET);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLOCK_COUNT: block_count_reg <= cfg_data[BCNT_W-1:0];
                CFG_BLOCK_SIZE:  block_size_reg  <= cfg_data[BSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign live_cnt = (XW'(block_count_reg) > XW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                              : CW'(block_count_reg);

    assign s_ready  = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        walk_cmd_next   = walk_cmd_reg;
        fc_next         = fc_reg;
        cnt_next        = cnt_reg;
        bi_next         = bi_reg;
        cand_next       = cand_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_free_next   = res_free_reg;
        prod_next       = prod_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        case (state_reg)
            ST_WALK: begin
                ram_we    = 1'b1;
                ram_waddr = walk_reg;
                ram_wdata = {1'b0, walk_reg};
                if (walk_reg == IW'(MAX_BLOCKS - 1)) begin
                    walk_next = '0;
                    if (walk_cmd_reg) begin
                        fc_next         = cnt_reg;
                        res_status_next = STATUS_OK;
                        res_idx_next    = '0;
                        res_free_next   = 1'b0;
                        state_next      = ST_MUL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    walk_next = IW'(walk_reg + 1'b1);
                end
            end
            ST_IDLE: begin
                ram_raddr = IW'(s_block_index);
                if (s_valid) begin
                    cnt_next        = live_cnt;
                    bi_next         = IW'(s_block_index);
                    res_status_next = STATUS_OK;
                    res_idx_next    = '0;
                    res_free_next   = 1'b0;
                    case (s_command)
                        CMD_INIT: begin
                            walk_next     = '0;
                            walk_cmd_next = 1'b1;
                            state_next    = ST_WALK;
                        end
                        CMD_ALLOC: state_next = ST_POP;
                        CMD_FREE, CMD_QUERY: begin
                            if (BW'(s_block_index) >= BW'(live_cnt)) begin
                                res_status_next = STATUS_RANGE;
                                state_next      = ST_MUL;
                            end else if (s_command == CMD_FREE) begin
                                state_next = ST_FREE_CHK;
                            end else begin
                                state_next = ST_QRY_CHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_POP: begin
                // pop the top entry; its word arrives next cycle
                ram_raddr = IW'(fc_reg - 1'b1);
                if (fc_reg == '0) begin
                    res_status_next = STATUS_NO_FREE;
                    state_next      = ST_MUL;
                end else begin
                    fc_next    = CW'(fc_reg - 1'b1);
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                ram_raddr = ram_rdata[IW-1:0];
                cand_next = ram_rdata[IW-1:0];
                if (CW'(ram_rdata[IW-1:0]) < cnt_reg) begin
                    state_next = ST_CHK;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_CHK: begin
                // drop stale entries whose block is already used
                if (!ram_rdata[IW]) begin
                    ram_we          = 1'b1;
                    ram_waddr       = cand_reg;
                    ram_wdata       = {1'b1, ram_rdata[IW-1:0]};
                    res_status_next = STATUS_OK;
                    res_idx_next    = cand_reg;
                    state_next      = ST_MUL;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_FREE_CHK: begin
                if (!ram_rdata[IW]) begin
                    state_next = ST_MUL;
                end else if (fc_reg >= cnt_reg) begin
                    res_status_next = STATUS_STACK_FULL;
                    state_next      = ST_MUL;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = bi_reg;
                    ram_wdata  = {1'b0, ram_rdata[IW-1:0]};
                    state_next = ST_FREE_RDS;
                end
            end
            ST_FREE_RDS: begin
                // read the push slot after the used flag clear has landed
                ram_raddr  = IW'(fc_reg);
                state_next = ST_FREE_SLOT;
            end
            ST_FREE_SLOT: begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(fc_reg);
                ram_wdata  = {ram_rdata[IW], bi_reg};
                fc_next    = CW'(fc_reg + 1'b1);
                state_next = ST_MUL;
            end
            ST_QRY_CHK: begin
                res_idx_next  = bi_reg;
                res_free_next = !ram_rdata[IW];
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PW'(block_size_reg) * PW'(res_idx_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_gidx_next   = m_gidx_reg;
        m_off_next    = m_off_reg;
        m_free_next   = m_free_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_gidx_next   = GIDX_W'(res_idx_reg);
            m_off_next    = OFF_W'(prod_reg);
            m_free_next   = res_free_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_WALK;
            walk_reg     <= '0;
            walk_cmd_reg <= 1'b0;
            fc_reg       <= CW'(RESET_FREE);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            walk_reg     <= walk_next;
            walk_cmd_reg <= walk_cmd_next;
            fc_reg       <= fc_next;
            m_valid_reg  <= m_valid_next;
        end
        cnt_reg        <= cnt_next;
        bi_reg         <= bi_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_free_reg   <= res_free_next;
        prod_reg       <= prod_next;
        m_status_reg   <= m_status_next;
        m_gidx_reg     <= m_gidx_next;
        m_off_reg      <= m_off_next;
        m_free_reg     <= m_free_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_gidx_reg;
    assign m_block_offset  = m_off_reg;
    assign m_is_free       = m_free_reg;

    `FBPA_ASSERT_IMPL(a_fc_bound, 1'b1, fc_reg <= CW'(MAX_BLOCKS), "free count above pool size")
    `FBPA_ASSERT_NEXT(a_push_inc, state_reg == ST_FREE_SLOT,
        fc_reg == CW'($past(fc_reg) + 1'b1), "push did not advance free count")
    `FBPA_ASSERT_NEXT(a_pop_empty, state_reg == ST_POP && fc_reg == '0,
        res_status_reg == STATUS_NO_FREE, "empty stack did not report no free block")
    `FBPA_ASSERT_IMPL(a_free_ok, m_valid_reg && m_free_reg,
        m_status_reg == STATUS_OK, "free flag set on a failed result")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Runs a short table of directed commands, then random command streams under
// several pool sizes and block sizes. A software copy of the packed free
// stack predicts the results that the directed rows do not give, and all
// results are checked on the response channel. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpa_pkg::*;

    localparam int POOL_BLOCKS     = 1024;
    localparam int PHASES          = 20;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CALM_PHASES     = 2;
    localparam int DRAIN_CYCLES    = 3 * POOL_BLOCKS + 8;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [GIDX_W-1:0] grant;
        logic [OFF_W-1:0]  offset;
        logic              is_free;
    } pool_result_t;

    typedef enum logic {ROW_COMMAND, ROW_REGISTER} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CMD_W-1:0]       cmd;
        logic [CFG_IDX_W-1:0]   sel;
        logic [CFG_DATA_W-1:0]  value;
        bit                     typed;
        pool_result_t           want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command = CMD_QUERY;
    logic [BIDX_W-1:0]     s_block_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STAT_W-1:0]     m_status;
    logic [GIDX_W-1:0]     m_granted_index;
    logic [OFF_W-1:0]      m_block_offset;
    logic                  m_is_free;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BLOCK_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Pool shadow: used flags and stack entries share slot numbering
    bit                    block_used [POOL_BLOCKS];
    logic [GIDX_W-1:0]     stack_slot [POOL_BLOCKS];
    int unsigned           stack_depth = POOL_BLOCKS;
    logic [BCNT_W-1:0]     blocks_cfg = BCNT_W'(BCNT_RESET);
    logic [BSIZE_W-1:0]    size_cfg = BSIZE_W'(BSIZE_RESET);

    pool_result_t          pending_results[$];
    stim_row_t             directed_rows[$];
    int                    mismatch_count = 0;
    int                    cmd_count [4] = '{default: 0};
    int                    status_seen [4] = '{default: 0};
    int                    reg_writes = 0;
    bit                    calm = 1'b0;
    bit                    quiet = 1'b0;
    int                    hold_left = 0;

    fixed_block_pool_allocator #(
        .MAX_BLOCKS(POOL_BLOCKS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_block_index   (s_block_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_block_offset  (m_block_offset),
        .m_is_free       (m_is_free),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            block_used[i] = 1'b0;
            stack_slot[i] = GIDX_W'(i);
        end
    end

    function automatic int unsigned live_blocks();
        return (blocks_cfg > POOL_BLOCKS) ? POOL_BLOCKS : int'(blocks_cfg);
    endfunction

    function automatic logic [OFF_W-1:0] offset_of(input int unsigned blk);
        logic [31:0] prod;
        prod = 32'(size_cfg) * 32'(blk);
        return prod[OFF_W-1:0];
    endfunction

    // Apply one command to the pool shadow and return its response
    function automatic pool_result_t predict_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [BIDX_W-1:0] idx);
        pool_result_t r;
        int unsigned  live;
        int unsigned  cand;
        bit           found;
        r = '0;
        live = live_blocks();
        found = 1'b0;
        case (cmd)
            CMD_INIT: begin
                for (int i = 0; i < POOL_BLOCKS; i++) begin
                    block_used[i] = 1'b0;
                    stack_slot[i] = GIDX_W'(i);
                end
                stack_depth = live;
            end
            CMD_ALLOC: begin
                r.status = STATUS_NO_FREE;
                // pop until a block that is in range and not in use turns up
                while (stack_depth > 0 && !found) begin
                    stack_depth--;
                    cand = stack_slot[stack_depth];
                    if (cand < live && !block_used[cand]) begin
                        block_used[cand] = 1'b1;
                        r.status = STATUS_OK;
                        r.grant = GIDX_W'(cand);
                        r.offset = offset_of(cand);
                        found = 1'b1;
                    end
                end
            end
            CMD_FREE: begin
                if (idx >= live) begin
                    r.status = STATUS_RANGE;
                end else if (!block_used[idx]) begin
                    r.status = STATUS_OK;
                end else if (stack_depth >= live) begin
                    r.status = STATUS_STACK_FULL;
                end else begin
                    // the slot being pushed keeps its own used flag
                    block_used[idx] = 1'b0;
                    stack_slot[stack_depth] = idx[GIDX_W-1:0];
                    stack_depth++;
                    r.status = STATUS_OK;
                end
            end
            default: begin
                if (idx >= live) begin
                    r.status = STATUS_RANGE;
                end else begin
                    r.status = STATUS_OK;
                    r.grant = idx[GIDX_W-1:0];
                    r.offset = offset_of(idx);
                    r.is_free = !block_used[idx];
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_cmd(input logic [CMD_W-1:0] cmd, input int idx);
        stim_row_t row;
        row = '{ROW_COMMAND, cmd, CFG_BLOCK_COUNT, CFG_DATA_W'(idx), 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [CMD_W-1:0] cmd, input int idx,
                                        input logic [STAT_W-1:0] st, input int grant,
                                        input int offset, input bit is_free);
        stim_row_t row;
        row = '{ROW_COMMAND, cmd, CFG_BLOCK_COUNT, CFG_DATA_W'(idx), 1'b1,
                '{st, GIDX_W'(grant), OFF_W'(offset), is_free}};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] sel,
                                      input logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{ROW_REGISTER, CMD_INIT, sel, data, 1'b0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Present one command and hold it until the allocator accepts it
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic [BIDX_W-1:0] idx,
                                 input bit typed, input pool_result_t want);
        pool_result_t model_r;
        cfg_valid <= 1'b0;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_block_index <= idx;
        do @(posedge aclk); while (!s_ready);
        model_r = predict_command(cmd, idx);
        pending_results.push_back(typed ? want : model_r);
        cmd_count[cmd]++;
    endtask

    task automatic idle_gap();
        int n;
        if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Register writes only go out once every response is back
    task automatic write_register(input logic [CFG_IDX_W-1:0] sel,
                                  input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (sel == CFG_BLOCK_COUNT)
            blocks_cfg = data[BCNT_W-1:0];
        else if (sel == CFG_BLOCK_SIZE)
            size_cfg = data;
        reg_writes++;
    endtask

    always @(posedge aclk) begin
        if (calm || quiet) begin
            hold_left = 0;
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected response, status %0d index %0d",
                                        m_status, m_granted_index));
            end else begin
                want = pending_results.pop_front();
                status_seen[m_status]++;
                if (want.status !== m_status || want.grant !== m_granted_index ||
                    want.offset !== m_block_offset || want.is_free !== m_is_free)
                    note_mismatch($sformatf({"expected status %0d index %0d offset %0d ",
                        "free %0d, got status %0d index %0d offset %0d free %0d"},
                        want.status, want.grant, want.offset, want.is_free,
                        m_status, m_granted_index, m_block_offset, m_is_free));
            end
        end
    end

    initial begin
        int unsigned         live;
        int unsigned         r;
        logic [CMD_W-1:0]    cmd;
        logic [BIDX_W-1:0]   idx;
        logic [BCNT_W-1:0]   count;
        logic [BSIZE_W-1:0]  size;
        int                  n;

        // Reset state: full pool of 1024 blocks, 64 bytes each
        add_checked(CMD_QUERY, 0, STATUS_OK, 0, 0, 1'b1);
        add_checked(CMD_QUERY, 1023, STATUS_OK, 1023, 65472, 1'b1);
        add_checked(CMD_QUERY, 1024, STATUS_RANGE, 0, 0, 1'b0);
        add_checked(CMD_FREE, 4095, STATUS_RANGE, 0, 0, 1'b0);
        add_checked(CMD_FREE, 5, STATUS_OK, 0, 0, 1'b0);
        add_checked(CMD_ALLOC, 0, STATUS_OK, 1023, 65472, 1'b0);
        add_checked(CMD_ALLOC, 0, STATUS_OK, 1022, 65408, 1'b0);
        add_checked(CMD_QUERY, 1022, STATUS_OK, 1022, 65408, 1'b0);
        add_checked(CMD_FREE, 1023, STATUS_OK, 0, 0, 1'b0);
        // shrink the pool so the stack counts as full with block 1022 in use
        add_write(CFG_BLOCK_COUNT, 16'd1023);
        add_checked(CMD_FREE, 1022, STATUS_STACK_FULL, 0, 0, 1'b0);
        add_cmd(CMD_ALLOC, 0);
        // empty pool: the alloc drains every stale entry
        add_write(CFG_BLOCK_COUNT, 16'd0);
        add_checked(CMD_ALLOC, 4095, STATUS_NO_FREE, 0, 0, 1'b0);
        add_checked(CMD_FREE, 0, STATUS_RANGE, 0, 0, 1'b0);
        add_checked(CMD_QUERY, 0, STATUS_RANGE, 0, 0, 1'b0);
        // oversized count saturates; largest offset
        add_write(CFG_BLOCK_COUNT, 16'h07FF);
        add_write(CFG_BLOCK_SIZE, 16'hFFFF);
        add_checked(CMD_QUERY, 1023, STATUS_OK, 1023, 67042305, 1'b1);
        add_write(CFG_BLOCK_SIZE, 16'd0);
        add_checked(CMD_QUERY, 7, STATUS_OK, 7, 0, 1'b1);
        add_checked(CMD_INIT, 0, STATUS_OK, 0, 0, 1'b0);
        add_checked(CMD_ALLOC, 0, STATUS_OK, 1023, 0, 1'b0);
        // single-block pool with a deep stack of stale entries
        add_write(CFG_BLOCK_COUNT, 16'd1);
        add_write(CFG_BLOCK_SIZE, 16'd1);
        add_cmd(CMD_ALLOC, 0);
        add_checked(CMD_ALLOC, 0, STATUS_NO_FREE, 0, 0, 1'b0);
        add_checked(CMD_FREE, 0, STATUS_OK, 0, 0, 1'b0);
        add_checked(CMD_QUERY, 1, STATUS_RANGE, 0, 0, 1'b0);
        // upper data bits are outside the count field
        add_write(CFG_BLOCK_COUNT, 16'hFC00);
        add_write(CFG_BLOCK_SIZE, 16'd64);
        add_checked(CMD_INIT, 4095, STATUS_OK, 0, 0, 1'b0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REGISTER) begin
                write_register(directed_rows[i].sel, directed_rows[i].value);
            end else begin
                issue_command(directed_rows[i].cmd, directed_rows[i].value[BIDX_W-1:0],
                              directed_rows[i].typed, directed_rows[i].want);
                idle_gap();
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase >= PHASES - CALM_PHASES);
            quiet = !calm && ($urandom_range(0, 3) == 0);

            // mostly small pools so they fill and drain often
            r = $urandom_range(0, 9);
            if (r <= 5)
                count = BCNT_W'($urandom_range(1, 16));
            else if (r == 6)
                count = BCNT_W'($urandom_range(17, 1024));
            else if (r == 7)
                count = BCNT_W'($urandom_range(1025, 2047));
            else if (r == 8)
                count = BCNT_W'(POOL_BLOCKS);
            else
                count = BCNT_W'($urandom_range(0, 3));
            r = $urandom_range(0, 5);
            if (r == 0)
                size = '0;
            else if (r == 1)
                size = '1;
            else if (r == 2)
                size = 16'd1;
            else
                size = BSIZE_W'($urandom);

            write_register(CFG_BLOCK_COUNT,
                           {($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0, count});
            write_register(CFG_BLOCK_SIZE, size);
            // skipping init now and then leaves stale entries on the stack
            if ($urandom_range(0, 3) != 0)
                issue_command(CMD_INIT, BIDX_W'($urandom), 1'b0, '0);

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                live = live_blocks();
                r = $urandom_range(0, 99);
                if (r < 2)
                    cmd = CMD_INIT;
                else if (r < 45)
                    cmd = CMD_ALLOC;
                else if (r < 78)
                    cmd = CMD_FREE;
                else
                    cmd = CMD_QUERY;
                r = $urandom_range(0, 9);
                if (live > 0 && r < 7)
                    idx = BIDX_W'($urandom_range(0, live - 1));
                else if (r == 7)
                    idx = BIDX_W'(live);
                else
                    idx = BIDX_W'($urandom_range(0, 4095));
                issue_command(cmd, idx, 1'b0, '0);
                idle_gap();
            end
        end
        s_valid <= 1'b0;

        n = 0;
        while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

        $display("covered %0d commands: init %0d, alloc %0d, free %0d, query %0d; %0d writes",
                 cmd_count[CMD_INIT] + cmd_count[CMD_ALLOC] + cmd_count[CMD_FREE] +
                 cmd_count[CMD_QUERY],
                 cmd_count[CMD_INIT], cmd_count[CMD_ALLOC], cmd_count[CMD_FREE],
                 cmd_count[CMD_QUERY], reg_writes);
        $display("responses: ok %0d, none free %0d, out of range %0d, stack full %0d; %0d bad",
                 status_seen[STATUS_OK], status_seen[STATUS_NO_FREE],
                 status_seen[STATUS_RANGE], status_seen[STATUS_STACK_FULL], mismatch_count);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
